// File: design/spcq_pkg.sv
// ---------------------------------------------------------------------------
// spcq_pkg: shared types and constants for the candidate queue
// Entry layout, command and status codes, cell actions, FSM states and
// the key ordering used by every cell.
// ---------------------------------------------------------------------------
package spcq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W   = 2;
    localparam int ID_W   = 32;
    localparam int DIST_W = 32;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 7;

    // find scan: match bits are looked at one chunk of lanes per cycle
    localparam int SCAN_LANES = 8;
    localparam int LANE_W     = $clog2(SCAN_LANES);
    localparam int NUM_CHUNKS = (QUEUE_DEPTH + SCAN_LANES - 1) / SCAN_LANES;
    localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int PAD_DEPTH  = NUM_CHUNKS * SCAN_LANES;

    localparam logic VertexRouter  = 1'b0;
    localparam logic VertexNetwork = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLEAR = 2'd3
    } spcq_op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } spcq_status_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic              kind;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_action_t;

    typedef struct packed {
        logic ahead;    // incoming key ranks strictly before this cell
        logic match;    // cell id equals the search key
    } cell_status_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] index;
    } find_status_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   result_id;
        logic [DIST_W-1:0] result_distance;
        logic              result_kind;
        logic [ID_W-1:0]   head_id;
        logic [DIST_W-1:0] head_distance;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND_START,
        S_FIND_WAIT
    } spcq_state_t;

    typedef enum logic {
        F_IDLE,
        F_SCAN
    } find_state_t;

    // smaller distance first; on a tie a network entry goes first
    function automatic logic ranks_before(input logic [DIST_W-1:0] da, input logic ka,
                                          input logic [DIST_W-1:0] db, input logic kb);
        logic r;
        r = (da < db) || ((da == db) && (ka == VertexNetwork) && (kb == VertexRouter));
        return r;
    endfunction

    function automatic result_t make_result(input logic [ST_W-1:0] st, input entry_t found,
                                            input entry_t head, input logic [CNT_W-1:0] cnt);
        result_t r;
        r.status          = st;
        r.result_id       = found.id;
        r.result_distance = found.distance;
        r.result_kind     = found.kind;
        r.is_empty        = (cnt == '0);
        r.head_id         = r.is_empty ? '0 : head.id;
        r.head_distance   = r.is_empty ? '0 : head.distance;
        r.occupancy       = OCC_W'(cnt);
        return r;
    endfunction

endpackage

// File: design/spcq_cmd_if.sv
// ---------------------------------------------------------------------------
// spcq_cmd_if: command channel
// valid/ready channel carrying one queue command word.
// ---------------------------------------------------------------------------
interface spcq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [spcq_pkg::OP_W-1:0]   operation;
    logic [spcq_pkg::ID_W-1:0]   vertex_id;
    logic [spcq_pkg::DIST_W-1:0] vertex_distance;
    logic                        vertex_kind;

    modport source (output valid, operation, vertex_id, vertex_distance, vertex_kind,
                    input ready);
    modport sink   (input valid, operation, vertex_id, vertex_distance, vertex_kind,
                    output ready);
endinterface

// File: design/spcq_rsp_if.sv
// ---------------------------------------------------------------------------
// spcq_rsp_if: response channel
// valid/ready channel carrying one result word per command.
// ---------------------------------------------------------------------------
interface spcq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [spcq_pkg::ST_W-1:0]   status;
    logic [spcq_pkg::ID_W-1:0]   result_id;
    logic [spcq_pkg::DIST_W-1:0] result_distance;
    logic                        result_kind;
    logic [spcq_pkg::ID_W-1:0]   head_id;
    logic [spcq_pkg::DIST_W-1:0] head_distance;
    logic [spcq_pkg::OCC_W-1:0]  occupancy;
    logic                        is_empty;

    modport source (output valid, status, result_id, result_distance, result_kind,
                    head_id, head_distance, occupancy, is_empty, input ready);
    modport sink   (input valid, status, result_id, result_distance, result_kind,
                    head_id, head_distance, occupancy, is_empty, output ready);
endinterface

// File: design/spcq_cell.sv
// ---------------------------------------------------------------------------
// spcq_cell: one slot of the sorted chain
// Holds one entry, compares it with the incoming key and search id, and
// loads from the new entry or a neighbor as told.
// ---------------------------------------------------------------------------
module spcq_cell (
    input  logic                         clk,
    input  spcq_pkg::cell_action_t       action,
    input  spcq_pkg::entry_t             new_entry,
    input  spcq_pkg::entry_t             left_entry,
    input  spcq_pkg::entry_t             right_entry,
    input  logic [spcq_pkg::ID_W-1:0]    key,
    output spcq_pkg::entry_t             entry,
    output spcq_pkg::cell_status_t       status
);

    spcq_pkg::entry_t entry_reg;
    spcq_pkg::entry_t entry_next;

    always_comb
    begin
        case (action)
            spcq_pkg::CELL_HOLD:       entry_next = entry_reg;
            spcq_pkg::CELL_LOAD_NEW:   entry_next = new_entry;
            spcq_pkg::CELL_FROM_LEFT:  entry_next = left_entry;
            spcq_pkg::CELL_FROM_RIGHT: entry_next = right_entry;
            default:                   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry         = entry_reg;
    assign status.ahead  = spcq_pkg::ranks_before(new_entry.distance, new_entry.kind,
                                                  entry_reg.distance, entry_reg.kind);
    assign status.match  = (entry_reg.id == key);

endmodule

// File: design/spcq_find.sv
// ---------------------------------------------------------------------------
// spcq_find: first-match scanner
// Captures the match bits of the chain and walks them one chunk of lanes
// per cycle, reporting the match nearest the head.
// ---------------------------------------------------------------------------
module spcq_find (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [spcq_pkg::QUEUE_DEPTH-1:0]  match,
    output spcq_pkg::find_status_t            status
);

    localparam int FULL_W = spcq_pkg::CHUNK_W + spcq_pkg::LANE_W;

    spcq_pkg::find_state_t                state_reg;
    spcq_pkg::find_state_t                state_next;
    logic [spcq_pkg::PAD_DEPTH-1:0]       match_reg;
    logic [spcq_pkg::PAD_DEPTH-1:0]       match_next;
    logic [spcq_pkg::CHUNK_W-1:0]         chunk_reg;
    logic [spcq_pkg::CHUNK_W-1:0]         chunk_next;

    logic [spcq_pkg::SCAN_LANES-1:0]      lane_bits;
    logic [spcq_pkg::LANE_W-1:0]          lane_idx;
    logic                                 lane_hit;
    logic                                 last_chunk;
    logic [FULL_W-1:0]                    full_idx;

    assign lane_bits  = match_reg[{chunk_reg, spcq_pkg::LANE_W'(0)} +: spcq_pkg::SCAN_LANES];
    assign last_chunk = (chunk_reg == spcq_pkg::CHUNK_W'(spcq_pkg::NUM_CHUNKS - 1));

    // lowest set lane wins
    always_comb
    begin
        lane_idx = '0;
        lane_hit = 1'b0;
        for (int i = spcq_pkg::SCAN_LANES - 1; i >= 0; i--)
        begin
            if (lane_bits[i])
            begin
                lane_idx = spcq_pkg::LANE_W'(i);
                lane_hit = 1'b1;
            end
        end
    end

    assign full_idx = {chunk_reg, lane_idx};

    // next state
    always_comb
    begin
        case (state_reg)
            spcq_pkg::F_IDLE: state_next = start ? spcq_pkg::F_SCAN : spcq_pkg::F_IDLE;
            spcq_pkg::F_SCAN: state_next = (lane_hit || last_chunk) ? spcq_pkg::F_IDLE
                                                                   : spcq_pkg::F_SCAN;
            default:          state_next = spcq_pkg::F_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        status.done = 1'b0;
        status.hit  = lane_hit;
        status.index = full_idx[spcq_pkg::IDX_W-1:0];
        match_next  = match_reg;
        chunk_next  = chunk_reg;
        case (state_reg)
            spcq_pkg::F_IDLE:
            begin
                if (start)
                begin
                    match_next = spcq_pkg::PAD_DEPTH'(match);
                    chunk_next = '0;
                end
            end
            spcq_pkg::F_SCAN:
            begin
                status.done = lane_hit || last_chunk;
                if (!(lane_hit || last_chunk))
                begin
                    chunk_next = chunk_reg + spcq_pkg::CHUNK_W'(1);
                end
            end
            default:
            begin
                status.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spcq_pkg::F_IDLE;
            chunk_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

endmodule

// File: design/shortest_path_candidate_queue_top.sv
// ---------------------------------------------------------------------------
// shortest_path_candidate_queue_top: sorted candidate queue
// Push, pop, find-by-id and clear over a chain of sorted entry cells.
// ---------------------------------------------------------------------------
// Push, pop and clear: the chain updates and the result word is registered in
//   the holding stage, then in the output register; no new command is taken
//   while the holding stage is full or a find runs. Find: the key is latched,
//   match bits are captured, then up to QUEUE_DEPTH/8 chunks (8 for depth 64)
//   are scanned, and the result word goes via the holding stage to the output.
// Reset clears the count and handshakes; cell contents stay unknown and are
//   never read past the count.
// ---------------------------------------------------------------------------
module shortest_path_candidate_queue_top (
    input  logic       clk,
    input  logic       rst_n,
    spcq_cmd_if.sink   cmd,
    spcq_rsp_if.source rsp
);

    localparam int DEPTH = spcq_pkg::QUEUE_DEPTH;

    // -----------------------------------------------------------------------
    // Control state
    // -----------------------------------------------------------------------
    spcq_pkg::spcq_state_t          state_reg;
    spcq_pkg::spcq_state_t          state_next;
    logic [spcq_pkg::CNT_W-1:0]     count_reg;
    logic [spcq_pkg::CNT_W-1:0]     count_next;
    logic [spcq_pkg::ID_W-1:0]      key_reg;
    logic [spcq_pkg::ID_W-1:0]      key_next;

    // result holding stage and output register
    spcq_pkg::result_t              res_reg;
    spcq_pkg::result_t              res_next;
    logic                           res_pending_reg;
    logic                           res_pending_next;
    spcq_pkg::result_t              out_reg;
    spcq_pkg::result_t              out_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // FSM outputs
    logic                           cmd_ready;
    logic                           find_start;

    // -----------------------------------------------------------------------
    // Command decode
    // -----------------------------------------------------------------------
    logic                           accept;
    spcq_pkg::entry_t               new_entry;
    logic                           is_full;
    logic                           is_zero;
    logic                           push_ok;
    logic                           pop_ok;

    assign accept             = cmd.valid && cmd_ready;
    assign new_entry.id       = cmd.vertex_id;
    assign new_entry.distance = cmd.vertex_distance;
    assign new_entry.kind     = cmd.vertex_kind;
    assign is_full            = (count_reg == spcq_pkg::CNT_W'(DEPTH));
    assign is_zero            = (count_reg == '0);
    assign push_ok = accept && (cmd.operation == spcq_pkg::OP_PUSH) && !is_full;
    assign pop_ok  = accept && (cmd.operation == spcq_pkg::OP_POP) && !is_zero;

    // -----------------------------------------------------------------------
    // Cell chain. Slot 0 is the head. A push finds its slot as the first
    // occupied cell the new key ranks before (or the first free cell); the
    // cells from there on shift one place back. A pop shifts all forward.
    // -----------------------------------------------------------------------
    spcq_pkg::entry_t               cell_q  [DEPTH];
    spcq_pkg::cell_status_t         cell_st [DEPTH];
    spcq_pkg::cell_action_t         cell_act[DEPTH];
    logic [DEPTH-1:0]               ins;
    logic [DEPTH-1:0]               match_vec;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             occ;
        logic             ins_prev;
        spcq_pkg::entry_t left_e;
        spcq_pkg::entry_t right_e;

        assign occ = (spcq_pkg::CNT_W'(i) < count_reg);
        // sorted order makes this set contiguous from the insert slot up to count
        assign ins[i] = (occ && cell_st[i].ahead) || (count_reg == spcq_pkg::CNT_W'(i));
        assign match_vec[i] = occ && cell_st[i].match;

        if (i == 0)
        begin : g_first
            assign ins_prev = 1'b0;
            assign left_e   = new_entry;
        end
        else
        begin : g_mid
            assign ins_prev = ins[i-1];
            assign left_e   = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = cell_q[i];
        end
        else
        begin : g_inner
            assign right_e = cell_q[i+1];
        end

        always_comb
        begin
            if (push_ok && ins[i])
            begin
                cell_act[i] = ins_prev ? spcq_pkg::CELL_FROM_LEFT : spcq_pkg::CELL_LOAD_NEW;
            end
            else if (pop_ok)
            begin
                cell_act[i] = spcq_pkg::CELL_FROM_RIGHT;
            end
            else
            begin
                cell_act[i] = spcq_pkg::CELL_HOLD;
            end
        end

        spcq_cell u_cell (
            .clk         (clk),
            .action      (cell_act[i]),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .key         (key_reg),
            .entry       (cell_q[i]),
            .status      (cell_st[i])
        );
    end

    // -----------------------------------------------------------------------
    // Find scanner
    // -----------------------------------------------------------------------
    spcq_pkg::find_status_t         find_st;

    spcq_find u_find (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (find_start),
        .match  (match_vec),
        .status (find_st)
    );

    // -----------------------------------------------------------------------
    // Result words
    // -----------------------------------------------------------------------
    spcq_pkg::entry_t               zero_entry;
    spcq_pkg::entry_t               head_after;
    spcq_pkg::entry_t               found_entry;
    spcq_pkg::result_t              res_direct;
    spcq_pkg::result_t              res_find;
    logic                           res_load;
    logic                           res_move;

    assign zero_entry = '0;

    always_comb
    begin
        if (push_ok)
        begin
            head_after = ins[0] ? new_entry : cell_q[0];
        end
        else if (pop_ok)
        begin
            head_after = cell_q[1];
        end
        else
        begin
            head_after = cell_q[0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + spcq_pkg::CNT_W'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - spcq_pkg::CNT_W'(1);
        end
        else if (accept && (cmd.operation == spcq_pkg::OP_CLEAR))
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        case (spcq_pkg::spcq_op_t'(cmd.operation))
            spcq_pkg::OP_PUSH:
                res_direct = spcq_pkg::make_result(is_full ? spcq_pkg::ST_FULL : spcq_pkg::ST_OK,
                                                   zero_entry, head_after, count_next);
            spcq_pkg::OP_POP:
                res_direct = spcq_pkg::make_result(is_zero ? spcq_pkg::ST_MISS : spcq_pkg::ST_OK,
                                                   is_zero ? zero_entry : cell_q[0],
                                                   head_after, count_next);
            default:
                res_direct = spcq_pkg::make_result(spcq_pkg::ST_OK, zero_entry,
                                                   head_after, count_next);
        endcase
    end

    assign found_entry = cell_q[find_st.index];
    assign res_find = spcq_pkg::make_result(find_st.hit ? spcq_pkg::ST_OK : spcq_pkg::ST_MISS,
                                            find_st.hit ? found_entry : zero_entry,
                                            cell_q[0], count_reg);

    assign res_load = (accept && (cmd.operation != spcq_pkg::OP_FIND)) ||
                      ((state_reg == spcq_pkg::S_FIND_WAIT) && find_st.done);
    assign res_move = res_pending_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        res_next         = res_reg;
        res_pending_next = res_pending_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        key_next         = key_reg;

        if (accept && (cmd.operation == spcq_pkg::OP_FIND))
        begin
            key_next = cmd.vertex_id;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_move)
        begin
            out_next         = res_reg;
            out_valid_next   = 1'b1;
            res_pending_next = 1'b0;
        end
        if (res_load)
        begin
            res_next         = (state_reg == spcq_pkg::S_FIND_WAIT) ? res_find : res_direct;
            res_pending_next = 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer: next state
    // -----------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            spcq_pkg::S_IDLE:
                state_next = (accept && (cmd.operation == spcq_pkg::OP_FIND))
                             ? spcq_pkg::S_FIND_START : spcq_pkg::S_IDLE;
            spcq_pkg::S_FIND_START:
                state_next = spcq_pkg::S_FIND_WAIT;
            spcq_pkg::S_FIND_WAIT:
                state_next = find_st.done ? spcq_pkg::S_IDLE : spcq_pkg::S_FIND_WAIT;
            default:
                state_next = spcq_pkg::S_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        cmd_ready  = 1'b0;
        find_start = 1'b0;
        case (state_reg)
            spcq_pkg::S_IDLE:       cmd_ready  = !res_pending_reg;
            spcq_pkg::S_FIND_START: find_start = 1'b1;
            spcq_pkg::S_FIND_WAIT:  cmd_ready  = 1'b0;
            default:                cmd_ready  = 1'b0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= spcq_pkg::S_IDLE;
            count_reg       <= '0;
            res_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            res_pending_reg <= res_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // -----------------------------------------------------------------------
    // Ports
    // -----------------------------------------------------------------------
    assign cmd.ready           = cmd_ready;
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.result_id       = out_reg.result_id;
    assign rsp.result_distance = out_reg.result_distance;
    assign rsp.result_kind     = out_reg.result_kind;
    assign rsp.head_id         = out_reg.head_id;
    assign rsp.head_distance   = out_reg.head_distance;
    assign rsp.occupancy       = out_reg.occupancy;
    assign rsp.is_empty        = out_reg.is_empty;

endmodule
